@@ rtl/bitmap_slot_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Concurrent checks on the clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BSA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap slot allocator: same-cycle check failed");

// Next-cycle implication.
`define BSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap slot allocator: next-cycle check failed");

`endif

@@ rtl/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int GROUP_BITS        = 8;
   localparam int MAX_SLOTS_DEFAULT = 256;
   localparam int CMD_W             = 3;
   localparam int SLOT_W            = 8;

   localparam logic [CMD_W-1:0] CMD_FIND_EMPTY = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MARK       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNMARK     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NEXT_USED  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GROW       = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture the request word
      logic scan;       // run one step of the group scan
      logic rmw_read;   // read the group addressed by the slot
      logic rmw_write;  // write the group back with the slot bit changed
      logic out_load;   // move the result into the output register
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_range;   // request slot lies inside the groups in use
      logic scan_hit;   // checked group holds a matching bit
      logic scan_end;   // every group in use has been checked
   } dp_status_type;

endpackage

@@ rtl/bsa_datapath.sv @@
// ----------------------------------------------------------------------------
// bsa_datapath
// Occupancy memory, group scanner, read-modify-write and result registers.
// ----------------------------------------------------------------------------
module bsa_datapath
   import bsa_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic              req_from_start,
   input  ctl_cmd_type       ctl_cmd,
   output dp_status_type     dp_status,
   output logic              rsp_found,
   output logic [SLOT_W-1:0] rsp_result_index
);

   localparam int GC  = MAX_SLOTS / GROUP_BITS;
   localparam int AW  = (GC > 1) ? $clog2(GC) : 1;
   localparam int GW  = $clog2(GC + 1);
   localparam int SGW = (GW > 6) ? GW : 6;

   logic [GROUP_BITS-1:0] mem [GC];
   logic [GROUP_BITS-1:0] rd_data_ff;

   logic [GW-1:0]     giu_ff, giu_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [SGW-1:0]    scan_grp_ff, chk_grp_ff;
   logic              first_ff, chk_first_ff;
   logic [2:0]        start_bit_ff;
   logic              want_ff;
   logic              set_bit_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              res_found_ff;
   logic [SLOT_W-1:0] res_index_ff;
   logic              rsp_found_ff;
   logic [SLOT_W-1:0] rsp_index_ff;

   logic [SGW-1:0]    giu_ext, req_grp_ext, idx_grp_ext;
   logic              giu_lt_max;
   logic              scan_issue;
   logic [8:0]        start_slot;
   logic [GROUP_BITS-1:0] chk_mask, cand, bit_mask;
   logic [2:0]        hit_bit;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [GROUP_BITS-1:0] mem_wdata;

   assign giu_ext     = SGW'(giu_ff);
   assign req_grp_ext = SGW'(req_slot_index[7:3]);
   assign idx_grp_ext = SGW'(idx_ff[7:3]);
   assign giu_lt_max  = (giu_ff < GW'(GC));

   assign start_slot = (req_command == CMD_NEXT_USED && !req_from_start)
                       ? ({1'b0, req_slot_index} + 9'd1) : 9'd0;

   assign scan_issue = ctl_cmd.scan && (scan_grp_ff < giu_ext);

   // Ignore bits below the start slot in the first group only
   assign chk_mask = chk_first_ff ? (8'hFF << start_bit_ff) : 8'hFF;
   assign cand     = (want_ff ? rd_data_ff : ~rd_data_ff) & chk_mask;

   always_comb begin
      hit_bit = 3'd0;
      for (int b = GROUP_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            hit_bit = 3'(b);
         end
      end
   end

   assign dp_status.in_range = (req_grp_ext < giu_ext);
   assign dp_status.scan_hit = chk_valid_ff && (cand != '0);
   assign dp_status.scan_end = !chk_valid_ff && !(scan_grp_ff < giu_ext);

   assign bit_mask  = 8'd1 << idx_ff[2:0];
   assign mem_re    = scan_issue || ctl_cmd.rmw_read;
   assign mem_raddr = ctl_cmd.rmw_read ? idx_grp_ext[AW-1:0] : scan_grp_ff[AW-1:0];
   assign mem_we    = ctl_cmd.rmw_write ||
                      (ctl_cmd.load && req_command == CMD_GROW && giu_lt_max);
   assign mem_waddr = ctl_cmd.rmw_write ? idx_grp_ext[AW-1:0] : giu_ext[AW-1:0];
   assign mem_wdata = !ctl_cmd.rmw_write ? '0 :
                      (set_bit_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      giu_in       = giu_ff;
      chk_valid_in = chk_valid_ff;
      if (ctl_cmd.load) begin
         chk_valid_in = 1'b0;
         if (req_command == CMD_GROW && giu_lt_max) begin
            giu_in = giu_ff + GW'(1);
         end
      end else if (ctl_cmd.scan) begin
         chk_valid_in = scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         giu_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         giu_ff       <= giu_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         idx_ff       <= req_slot_index;
         set_bit_ff   <= (req_command == CMD_MARK);
         want_ff      <= (req_command == CMD_NEXT_USED);
         scan_grp_ff  <= SGW'(start_slot[8:3]);
         start_bit_ff <= start_slot[2:0];
         first_ff     <= 1'b1;
         case (req_command)
            CMD_MARK, CMD_UNMARK: begin
               res_found_ff <= dp_status.in_range;
               res_index_ff <= '0;
            end
            CMD_GROW: begin
               res_found_ff <= giu_lt_max;
               res_index_ff <= giu_lt_max ? {giu_ext[4:0], 3'b000} : '0;
            end
            default: begin
               res_found_ff <= 1'b0;
               res_index_ff <= '0;
            end
         endcase
      end else if (ctl_cmd.scan) begin
         if (scan_issue) begin
            chk_grp_ff   <= scan_grp_ff;
            chk_first_ff <= first_ff;
            first_ff     <= 1'b0;
            scan_grp_ff  <= scan_grp_ff + SGW'(1);
         end
         if (dp_status.scan_hit) begin
            res_found_ff <= 1'b1;
            res_index_ff <= {chk_grp_ff[4:0], hit_bit};
         end else if (dp_status.scan_end) begin
            res_found_ff <= 1'b0;
            res_index_ff <= '0;
         end
      end
      if (ctl_cmd.out_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_index_ff <= res_index_ff;
      end
   end

   assign rsp_found        = rsp_found_ff;
   assign rsp_result_index = rsp_index_ff;

endmodule

@@ rtl/bsa_controller.sv @@
// ----------------------------------------------------------------------------
// bsa_controller
// Command sequencer and response valid for the bitmap slot allocator.
// ----------------------------------------------------------------------------
module bsa_controller
   import bsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CMD_W-1:0] req_command,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dp_status_type    dp_status,
   output ctl_cmd_type      ctl_cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_RMW_RD = 5'b00100,
      ST_RMW_WR = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.load = 1'b1;
               case (req_command)
                  CMD_FIND_EMPTY, CMD_NEXT_USED: state_in = ST_SCAN;
                  CMD_MARK, CMD_UNMARK:
                     state_in = dp_status.in_range ? ST_RMW_RD : ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            ctl_cmd.scan = 1'b1;
            if (dp_status.scan_hit || dp_status.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_RMW_RD: begin
            ctl_cmd.rmw_read = 1'b1;
            state_in         = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            ctl_cmd.rmw_write = 1'b1;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               ctl_cmd.out_load = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Slot occupancy bitmap with find, mark, unmark, next-used and grow commands.
// ----------------------------------------------------------------------------
// Usage:
//  The req_ channel takes one command word (command, slot index, from-start
//  flag); the rsp_ channel returns one word per command (found, result index).
//  Both use valid/ready; a word moves when valid and ready are high together.
//  One command is worked at a time. Its path through the controller states:
//    grow and unused codes            straight to done
//    mark/unmark in range             read, then write back one group
//    mark/unmark out of range         straight to done
//    find_empty/next_used             scan the groups in use, to a hit or the end
//  The scan reads one eight-bit group per cycle through the single read port
//  of the occupancy memory, so search time grows with the groups in use.
//  The result sits in an output register: a new command is accepted as soon
//  as the previous one is handed over, even while the receiver stalls; a
//  finished command waits only if the output register still holds a word.
//  Reset empties the bitmap (no groups in use) and drops any pending word;
//  no clearing pass is needed, since grow clears each group as it adds it.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic              req_from_start,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [SLOT_W-1:0] rsp_result_index
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;
   logic [3:0]    ctl_steps;

   bsa_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_status   (dp_status),
      .ctl_cmd     (ctl_cmd)
   );

   bsa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_slot_index   (req_slot_index),
      .req_from_start   (req_from_start),
      .ctl_cmd          (ctl_cmd),
      .dp_status        (dp_status),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index)
   );

   assign ctl_steps = {ctl_cmd.scan, ctl_cmd.rmw_read, ctl_cmd.rmw_write, ctl_cmd.out_load};

   `BSA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   `BSA_ASSERT_NOW(a_no_overwrite, ctl_cmd.out_load, !rsp_valid || rsp_ready)
   `BSA_ASSERT_NOW(a_one_step, 1'b1, $onehot0(ctl_steps))
   `BSA_ASSERT_NOW(a_miss_index_zero, rsp_valid && !rsp_found, rsp_result_index == '0)

endmodule
